[design/jcdn_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package jcdn_pkg;

    localparam int YEAR_W   = 14;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int DAYNUM_W = 23;
    localparam int OYEAR_W  = 16;
    localparam int WDAY_W   = 3;

    localparam logic FUNC_ENCODE = 1'b0;
    localparam logic FUNC_DECODE = 1'b1;

    localparam logic [10:0] DAYS_PER_4Y  = 11'd1461;
    localparam logic [12:0] YEAR_BIAS    = 13'd4716;
    localparam logic [12:0] YEAR_BIAS_JF = 13'd4715;
    localparam logic [10:0] DAY_BIAS     = 11'd1524;
    localparam logic [4:0]  B_SCALE      = 5'd20;
    localparam logic [11:0] B_OFFSET     = 12'd2442;
    localparam logic [2:0]  SUNDAY       = 3'd7;

    // exact reciprocal multiply: floor(t / 7305) for t < 2^28
    localparam int          CDIV_SHIFT = 41;
    localparam logic [28:0] CDIV_MAGIC =
        29'(((64'd1 << CDIV_SHIFT) + 64'd7304) / 64'd7305);

    // exact reciprocal multiply: floor(x / 7) for x < 2^24
    localparam int          WDIV_SHIFT = 27;
    localparam logic [24:0] WDIV_MAGIC =
        25'(((64'd1 << WDIV_SHIFT) + 64'd6) / 64'd7);

    typedef struct packed {
        logic signed [OYEAR_W-1:0] year;
        logic [MONTH_W-1:0]        month;
        logic [DAY_W-1:0]          day;
        logic [WDAY_W-1:0]         weekday;
    } dec_result_t;

    // floor(30.6001 * e)
    function automatic logic [8:0] month_offset(input logic [3:0] e);
        logic [8:0] v;
        unique case (e)
            4'd0:  v = 9'd0;
            4'd1:  v = 9'd30;
            4'd2:  v = 9'd61;
            4'd3:  v = 9'd91;
            4'd4:  v = 9'd122;
            4'd5:  v = 9'd153;
            4'd6:  v = 9'd183;
            4'd7:  v = 9'd214;
            4'd8:  v = 9'd244;
            4'd9:  v = 9'd275;
            4'd10: v = 9'd306;
            4'd11: v = 9'd336;
            4'd12: v = 9'd367;
            4'd13: v = 9'd397;
            4'd14: v = 9'd428;
            4'd15: v = 9'd459;
        endcase
        return v;
    endfunction

    function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
        logic [4:0] v;
        unique case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: v = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                   v = 5'd30;
            4'd2:                                      v = leap ? 5'd29 : 5'd28;
            default:                                   v = 5'd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

[design/julian_calendar_day_number_convert.sv]
// Julian-calendar date to day number converter and back, fully pipelined.
// A request is taken on every clock at which start is high; busy is never
// raised, so requests may follow each other with no gap. Each result leaves
// through the encoder or decoder register stages and the output registers,
// in request order, on the output ports for one cycle with done high; the
// receiver cannot stall and must take it then. The pipeline holds the
// constant-reciprocal multiplies (divide by 7305 and by 7) and the
// 365.25-day multiply, each followed by a register stage.
`timescale 1ns / 1ps
`default_nettype none

module julian_calendar_day_number_convert
    import jcdn_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic                       func,
    input  logic [YEAR_W-1:0]          in_year,
    input  logic [MONTH_W-1:0]         in_month,
    input  logic [DAY_W-1:0]           in_day,
    input  logic [DAYNUM_W-1:0]        in_day_number,
    output logic                       done,
    output logic [DAYNUM_W-1:0]        out_day_number,
    output logic signed [OYEAR_W-1:0]  out_year,
    output logic [MONTH_W-1:0]         out_month,
    output logic [DAY_W-1:0]           out_day,
    output logic [WDAY_W-1:0]          weekday,
    output logic                       invalid_date
);

    logic [3:0]          vld_reg;
    logic [3:0]          func_reg;
    logic                accept;

    logic [DAYNUM_W-1:0] enc_num;
    logic                enc_bad;
    dec_result_t         dec;

    logic                done_reg;
    logic [DAYNUM_W-1:0] num_reg;
    logic [OYEAR_W-1:0]  year_reg;
    logic [MONTH_W-1:0]  month_reg;
    logic [DAY_W-1:0]    day_reg;
    logic [WDAY_W-1:0]   wd_reg;
    logic                bad_reg;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    jcdn_encode u_encode (
        .clk        (clk),
        .year       (in_year),
        .month      (in_month),
        .day        (in_day),
        .day_number (enc_num),
        .invalid    (enc_bad)
    );

    jcdn_decode u_decode (
        .clk        (clk),
        .day_number (in_day_number),
        .result     (dec)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            vld_reg  <= {vld_reg[2:0], accept};
            done_reg <= vld_reg[3];
        end
    end

    // result select by function code
    always_ff @(posedge clk)
    begin
        func_reg <= {func_reg[2:0], func};
        if (func_reg[3] == FUNC_DECODE)
        begin
            num_reg   <= '0;
            bad_reg   <= 1'b0;
            year_reg  <= dec.year;
            month_reg <= dec.month;
            day_reg   <= dec.day;
            wd_reg    <= dec.weekday;
        end
        else
        begin
            num_reg   <= enc_num;
            bad_reg   <= enc_bad;
            year_reg  <= '0;
            month_reg <= '0;
            day_reg   <= '0;
            wd_reg    <= '0;
        end
    end

    assign done           = done_reg;
    assign out_day_number = num_reg;
    assign out_year       = $signed(year_reg);
    assign out_month      = month_reg;
    assign out_day        = day_reg;
    assign weekday        = wd_reg;
    assign invalid_date   = bad_reg;

endmodule

`default_nettype wire

[design/jcdn_encode.sv]
`timescale 1ns / 1ps
`default_nettype none

module jcdn_encode
    import jcdn_pkg::*;
(
    input  logic                clk,
    input  logic [YEAR_W-1:0]   year,
    input  logic [MONTH_W-1:0]  month,
    input  logic [DAY_W-1:0]    day,
    output logic [DAYNUM_W-1:0] day_number,
    output logic                invalid
);

    logic        leap;
    logic        bad;
    logic        early;
    logic [14:0] s1_yy_next;
    logic [3:0]  s1_e_next;

    logic        s1_bad_reg;
    logic [14:0] s1_yy_reg;
    logic [3:0]  s1_e_reg;
    logic [4:0]  s1_day_reg;

    logic [25:0] s2_prod_next;
    logic        s2_bad_reg;
    logic [25:0] s2_prod_reg;
    logic [3:0]  s2_e_reg;
    logic [4:0]  s2_day_reg;

    logic [24:0]         sum;
    logic [DAYNUM_W-1:0] s3_num_next;
    logic [DAYNUM_W-1:0] s3_num_reg;
    logic                s3_bad_reg;
    logic [DAYNUM_W-1:0] s4_num_reg;
    logic                s4_bad_reg;

    // range checks and jan/feb shift to previous year
    always_comb
    begin
        leap  = (year[1:0] == 2'b00);
        bad   = (year == '0) || (month < 4'd1) || (month > 4'd12) || (day == '0) ||
                (day > month_days(month, leap));
        early = (month <= 4'd2);
        s1_yy_next = 15'(year) - 15'(early) + 15'(YEAR_BIAS);
        s1_e_next  = early ? 4'(month + 4'd13) : 4'(month + 4'd1);
    end

    // years times 365.25
    assign s2_prod_next = 26'(26'(s1_yy_reg) * 26'(DAYS_PER_4Y));

    always_comb
    begin
        sum = 25'(s2_prod_reg[25:2]) + 25'(month_offset(s2_e_reg)) + 25'(s2_day_reg)
              - 25'(DAY_BIAS);
        s3_num_next = s2_bad_reg ? '0 : sum[DAYNUM_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        s1_bad_reg  <= bad;
        s1_yy_reg   <= s1_yy_next;
        s1_e_reg    <= s1_e_next;
        s1_day_reg  <= day;
        s2_bad_reg  <= s1_bad_reg;
        s2_prod_reg <= s2_prod_next;
        s2_e_reg    <= s1_e_reg;
        s2_day_reg  <= s1_day_reg;
        s3_num_reg  <= s3_num_next;
        s3_bad_reg  <= s2_bad_reg;
        s4_num_reg  <= s3_num_reg;
        s4_bad_reg  <= s3_bad_reg;
    end

    assign day_number = s4_num_reg;
    assign invalid    = s4_bad_reg;

endmodule

`default_nettype wire

[design/jcdn_decode.sv]
`timescale 1ns / 1ps
`default_nettype none

module jcdn_decode
    import jcdn_pkg::*;
(
    input  logic                clk,
    input  logic [DAYNUM_W-1:0] day_number,
    output dec_result_t         result
);

    logic [23:0] s1_b_next;
    logic [27:0] s1_t_next;
    logic [23:0] s1_x7_next;
    logic [23:0] s1_b_reg;
    logic [27:0] s1_t_reg;
    logic [23:0] s1_x7_reg;

    logic [56:0] s2_cprod_next;
    logic [48:0] s2_wprod_next;
    logic [56:0] s2_cprod_reg;
    logic [48:0] s2_wprod_reg;
    logic [23:0] s2_b_reg;
    logic [23:0] s2_x7_reg;

    logic [21:0] wq;
    logic [24:0] wr_full;
    logic [2:0]  wr;
    logic [2:0]  s3_wd_next;
    logic [14:0] s3_c_reg;
    logic [2:0]  s3_wd_reg;
    logic [23:0] s3_b_reg;

    logic [25:0] dd_full;
    logic [23:0] s4_dd_reg;
    logic [14:0] s4_c_reg;
    logic [2:0]  s4_wd_reg;
    logic [23:0] s4_b_reg;

    logic [23:0] x_full;
    logic [8:0]  x;
    logic [3:0]  e;
    logic [8:0]  day_full;
    logic [3:0]  mon;

    always_comb
    begin
        s1_b_next  = 24'(day_number) + 24'(DAY_BIAS);
        s1_t_next  = 28'(28'(s1_b_next) * 28'(B_SCALE)) - 28'(B_OFFSET);
        s1_x7_next = 24'(day_number) + 24'd1;
    end

    // reciprocal multiplies for /7305 and /7
    assign s2_cprod_next = 57'(57'(s1_t_reg) * 57'(CDIV_MAGIC));
    assign s2_wprod_next = 49'(49'(s1_x7_reg) * 49'(WDIV_MAGIC));

    // weekday remainder
    always_comb
    begin
        wq      = s2_wprod_reg[48:WDIV_SHIFT];
        wr_full = 25'(s2_x7_reg) - (25'(wq) << 3) + 25'(wq);
        wr      = wr_full[2:0];
        s3_wd_next = (wr == 3'd0) ? SUNDAY : wr;
    end

    assign dd_full = 26'(26'(s3_c_reg) * 26'(DAYS_PER_4Y));

    // month search over the 30.6001 table, then day and year
    always_comb
    begin
        x_full = s4_b_reg - s4_dd_reg;
        x      = x_full[8:0];
        e      = 4'd0;
        for (int k = 1; k < 16; k++)
        begin
            if (month_offset(4'(k)) < x)
            begin
                e = 4'(k);
            end
        end
        day_full = x - month_offset(e);
        mon      = (e < 4'd14) ? 4'(e - 4'd1) : 4'(e - 4'd13);
        result.day     = day_full[DAY_W-1:0];
        result.month   = mon;
        result.weekday = s4_wd_reg;
        result.year    = (mon > 4'd2) ? $signed(16'(s4_c_reg) - 16'(YEAR_BIAS))
                                      : $signed(16'(s4_c_reg) - 16'(YEAR_BIAS_JF));
    end

    always_ff @(posedge clk)
    begin
        s1_b_reg     <= s1_b_next;
        s1_t_reg     <= s1_t_next;
        s1_x7_reg    <= s1_x7_next;
        s2_cprod_reg <= s2_cprod_next;
        s2_wprod_reg <= s2_wprod_next;
        s2_b_reg     <= s1_b_reg;
        s2_x7_reg    <= s1_x7_reg;
        s3_c_reg     <= s2_cprod_reg[55:CDIV_SHIFT];
        s3_wd_reg    <= s3_wd_next;
        s3_b_reg     <= s2_b_reg;
        s4_dd_reg    <= dd_full[25:2];
        s4_c_reg     <= s3_c_reg;
        s4_wd_reg    <= s3_wd_reg;
        s4_b_reg     <= s3_b_reg;
    end

endmodule

`default_nettype wire

[tb/tb_julian_calendar_day_number_convert.sv]
`timescale 1ns / 1ps

module tb_julian_calendar_day_number_convert;
    import jcdn_pkg::*;

    localparam int   NUM_RANDOM  = 1530;
    localparam int   STALL_LIMIT = 1000;
    localparam int   DRAIN_CYCLES = 20;

    typedef struct packed {
        logic                  func;
        logic [YEAR_W-1:0]     year;
        logic [MONTH_W-1:0]    month;
        logic [DAY_W-1:0]      day;
        logic [DAYNUM_W-1:0]   day_number;
    } conv_request_t;

    typedef struct packed {
        logic [DAYNUM_W-1:0]        day_number;
        logic signed [OYEAR_W-1:0]  year;
        logic [MONTH_W-1:0]         month;
        logic [DAY_W-1:0]           day;
        logic [WDAY_W-1:0]          weekday;
        logic                       invalid;
    } conv_result_t;

    class calendar_scoreboard;
        conv_result_t pending_conversions[$];
        int           mismatch_count;

        function new();
            mismatch_count = 0;
        endfunction

        static function int unsigned days_in_month(int unsigned y, int unsigned m);
            case (m)
                2:          return (y % 4 == 0) ? 29 : 28;
                4, 6, 9, 11: return 30;
                default:    return 31;
            endcase
        endfunction

        function conv_result_t convert_date(conv_request_t r);
            conv_result_t res;
            int unsigned  y, m, d, n, b, c, dd, e, dy, mo, wd;
            int           yr;
            bit           bad;
            res = '0;
            if (r.func == FUNC_ENCODE)
            begin
                y = r.year;
                m = r.month;
                d = r.day;
                bad = (y == 0) || (m < 1) || (m > 12) || (d == 0);
                if (!bad)
                    bad = d > days_in_month(y, m);
                if (bad)
                begin
                    res.invalid = 1'b1;
                end
                else
                begin
                    // january and february count as months 13 and 14 of the prior year
                    if (m <= 2)
                    begin
                        y = y - 1;
                        m = m + 12;
                    end
                    n = (1461 * (y + 4716)) / 4 + (306001 * (m + 1)) / 10000 + d - 1524;
                    res.day_number = n[DAYNUM_W-1:0];
                end
            end
            else
            begin
                n  = r.day_number;
                b  = n + 1524;
                c  = (20 * b - 2442) / 7305;
                dd = (1461 * c) / 4;
                e  = (10000 * (b - dd)) / 306001;
                dy = b - dd - (306001 * e) / 10000;
                mo = (e < 14) ? e - 1 : e - 13;
                yr = (mo > 2) ? int'(c) - 4716 : int'(c) - 4715;
                wd = (n + 1) % 7;
                if (wd == 0)
                    wd = 7;
                res.year    = yr[OYEAR_W-1:0];
                res.month   = mo[MONTH_W-1:0];
                res.day     = dy[DAY_W-1:0];
                res.weekday = wd[WDAY_W-1:0];
            end
            return res;
        endfunction

        function void note_request(conv_request_t r);
            pending_conversions.push_back(convert_date(r));
        endfunction

        function void check_result(conv_result_t got);
            conv_result_t want;
            if (pending_conversions.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("%0t: unexpected result dn=%0d yr=%0d mo=%0d dy=%0d wd=%0d inv=%0b",
                             $realtime, got.day_number, got.year, got.month, got.day,
                             got.weekday, got.invalid);
                return;
            end
            want = pending_conversions.pop_front();
            if (got !== want)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("%0t: result differs exp dn=%0d yr=%0d mo=%0d dy=%0d wd=%0d inv=%0b%s",
                             $realtime, want.day_number, want.year, want.month, want.day,
                             want.weekday, want.invalid,
                             $sformatf(" got dn=%0d yr=%0d mo=%0d dy=%0d wd=%0d inv=%0b",
                                       got.day_number, got.year, got.month, got.day,
                                       got.weekday, got.invalid));
            end
        endfunction
    endclass

    logic                       clk;
    logic                       rst_n;
    logic                       start;
    logic                       busy;
    logic                       func;
    logic [YEAR_W-1:0]          in_year;
    logic [MONTH_W-1:0]         in_month;
    logic [DAY_W-1:0]           in_day;
    logic [DAYNUM_W-1:0]        in_day_number;
    logic                       done;
    logic [DAYNUM_W-1:0]        out_day_number;
    logic signed [OYEAR_W-1:0]  out_year;
    logic [MONTH_W-1:0]         out_month;
    logic [DAY_W-1:0]           out_day;
    logic [WDAY_W-1:0]          weekday;
    logic                       invalid_date;

    calendar_scoreboard sb;
    int                 idle_pct;
    int                 quiet_cycles;

    julian_calendar_day_number_convert dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .func           (func),
        .in_year        (in_year),
        .in_month       (in_month),
        .in_day         (in_day),
        .in_day_number  (in_day_number),
        .done           (done),
        .out_day_number (out_day_number),
        .out_year       (out_year),
        .out_month      (out_month),
        .out_day        (out_day),
        .weekday        (weekday),
        .invalid_date   (invalid_date)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic conv_request_t noise_request();
        conv_request_t r;
        r.func       = 1'($urandom);
        r.year       = YEAR_W'($urandom);
        r.month      = MONTH_W'($urandom);
        r.day        = DAY_W'($urandom);
        r.day_number = DAYNUM_W'($urandom);
        return r;
    endfunction

    task automatic apply_inputs(input conv_request_t r);
        func          = r.func;
        in_year       = r.year;
        in_month      = r.month;
        in_day        = r.day;
        in_day_number = r.day_number;
    endtask

    task automatic send_request(input conv_request_t r);
        while ($urandom_range(99) < idle_pct)
        begin
            @(negedge clk);
            start = 1'b0;
            apply_inputs(noise_request());
        end
        @(negedge clk);
        start = 1'b1;
        apply_inputs(r);
        do
            @(posedge clk);
        while (busy);
    endtask

    task automatic encode_date(input int unsigned y, input int unsigned m, input int unsigned d);
        conv_request_t r;
        r       = noise_request();
        r.func  = FUNC_ENCODE;
        r.year  = YEAR_W'(y);
        r.month = MONTH_W'(m);
        r.day   = DAY_W'(d);
        send_request(r);
    endtask

    task automatic decode_number(input int unsigned n);
        conv_request_t r;
        r            = noise_request();
        r.func       = FUNC_DECODE;
        r.day_number = DAYNUM_W'(n);
        send_request(r);
    endtask

    task automatic send_random_request();
        conv_request_t r;
        int unsigned   roll, y, m, lim;
        roll = $urandom_range(99);
        if (roll < 45)
        begin
            y   = ($urandom_range(4) == 0) ? $urandom_range(1, 16383) : $urandom_range(1, 9999);
            m   = $urandom_range(1, 12);
            lim = calendar_scoreboard::days_in_month(y, m);
            encode_date(y, m, ($urandom_range(3) == 0) ? lim : $urandom_range(1, lim));
        end
        else if (roll < 60)
        begin
            r      = noise_request();
            r.func = FUNC_ENCODE;
            send_request(r);
        end
        else if (roll < 80)
        begin
            decode_number($urandom_range(1721424, 5373484));
        end
        else
        begin
            decode_number(DAYNUM_W'($urandom));
        end
    endtask

    // checks results, notes accepted requests, and watches for a hang
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
                sb.check_result({out_day_number, out_year, out_month, out_day,
                                 weekday, invalid_date});
            if (start && !busy)
                sb.note_request({func, in_year, in_month, in_day, in_day_number});
            if (done || (start && !busy))
                quiet_cycles = 0;
            else
                quiet_cycles = quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("julian_calendar_day_number_convert: mismatch");
                $finish;
            end
        end
    end

    initial
    begin
        sb            = new();
        quiet_cycles  = 0;
        idle_pct      = 38;
        rst_n         = 1'b0;
        start         = 1'b0;
        func          = FUNC_ENCODE;
        in_year       = '0;
        in_month      = '0;
        in_day        = '0;
        in_day_number = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // date extremes and invalid dates
        encode_date(1, 1, 1);
        encode_date(16383, 12, 31);
        encode_date(9999, 12, 31);
        encode_date(4, 2, 29);
        encode_date(3, 2, 29);
        encode_date(3, 2, 28);
        encode_date(4, 2, 30);
        encode_date(0, 6, 15);
        encode_date(2000, 0, 10);
        encode_date(2000, 13, 10);
        encode_date(2000, 15, 31);
        encode_date(2000, 7, 0);
        encode_date(2001, 4, 31);
        encode_date(2001, 1, 31);
        encode_date(1582, 3, 1);
        // day number extremes, known dates, sunday wraparound
        decode_number(0);
        decode_number(8388607);
        decode_number(2299160);
        decode_number(1721424);
        decode_number(1721423);
        decode_number(6);
        decode_number(5373484);

        for (int i = 0; i < NUM_RANDOM; i++)
        begin
            idle_pct = (i >= 600 && i < 900) ? 0 : 38;
            send_random_request();
        end
        @(negedge clk);
        start = 1'b0;

        while (sb.pending_conversions.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.mismatch_count == 0 && sb.pending_conversions.size() == 0)
            $display("julian_calendar_day_number_convert: match");
        else
            $display("julian_calendar_day_number_convert: mismatch");
        $finish;
    end

endmodule
